[rtl/thrs_pkg.sv]
//------------------------------------------------------------------------------
// thrs_pkg: shared types and constants
// Field widths, CORDIC table and the row tag type carried in the front-to-back queue.
//------------------------------------------------------------------------------
`default_nettype none
package thrs_pkg;

  localparam int DEG_W       = 7;
  localparam int MULT_W      = 4;
  localparam int CORDIC_STEPS = 16;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_L     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LP    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_F     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_D     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OM    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEG   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ORD   = 4'd7;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd326016437;

  // Arctangent per step, turns times 2^32
  function automatic logic signed [33:0] atan_turns(input logic [3:0] i);
    unique case (i)
      4'd0:  atan_turns = 34'sd536870912;
      4'd1:  atan_turns = 34'sd316933406;
      4'd2:  atan_turns = 34'sd167458907;
      4'd3:  atan_turns = 34'sd85004756;
      4'd4:  atan_turns = 34'sd42667331;
      4'd5:  atan_turns = 34'sd21354465;
      4'd6:  atan_turns = 34'sd10679838;
      4'd7:  atan_turns = 34'sd5340247;
      4'd8:  atan_turns = 34'sd2670163;
      4'd9:  atan_turns = 34'sd1335087;
      4'd10: atan_turns = 34'sd667544;
      4'd11: atan_turns = 34'sd333772;
      4'd12: atan_turns = 34'sd166886;
      4'd13: atan_turns = 34'sd83443;
      4'd14: atan_turns = 34'sd41722;
      default: atan_turns = 34'sd20861;
    endcase
  endfunction

  // Row attributes carried alongside the phase
  typedef struct packed {
    logic [DEG_W-1:0] degree;
    logic [DEG_W-1:0] order;
    logic             bad;
  } row_tag_t;

endpackage
`default_nettype wire

[rtl/thrs_front.sv]
//------------------------------------------------------------------------------
// thrs_front: row filter and phase former
// Checks limits, drops rows outside them when the limits are valid, and forms the 32-bit theta.
//------------------------------------------------------------------------------
`default_nettype none
module thrs_front import thrs_pkg::*; #(
  parameter int TABLE_DEGREE = 100,
  parameter int ANGLE_BITS = 32,
  parameter int COEF_BITS  = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [ANGLE_BITS-1:0]       beta [6],
  input  wire logic [DEG_W-1:0]            deg_limit,
  input  wire logic [DEG_W-1:0]            ord_limit,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [DEG_W-1:0]            degree,
  input  wire logic [DEG_W-1:0]            order,
  input  wire logic [MULT_W-1:0]           mult [6],
  input  wire logic [4*COEF_BITS-1:0]      coefs,
  output logic                             q_valid,
  input  wire logic                        q_ready,
  output row_tag_t                         q_tag,
  output logic [31:0]                      q_theta,
  output logic [4*COEF_BITS-1:0]           q_coefs
);

  logic              bad, drop;
  logic [ANGLE_BITS-1:0] prod [6];
  logic [ANGLE_BITS-1:0] theta;
  logic [31:0]       ph;

  assign bad = (deg_limit < DEG_W'(2)) || (32'(deg_limit) > TABLE_DEGREE) ||
               (ord_limit > deg_limit);
  assign drop = !bad && ((degree > deg_limit) || (order > ord_limit));

  // Multiply each argument by its small multiplier (unsigned for the first, signed for the rest), modulo one turn
  always_comb begin
    theta = '0;
    for (int i = 0; i < 6; i++) begin
      if (i == 0) prod[i] = beta[i] * ANGLE_BITS'(mult[i]);
      else prod[i] = beta[i] * ANGLE_BITS'({{(ANGLE_BITS-MULT_W){mult[i][MULT_W-1]}}, mult[i]});
      theta = theta + prod[i];
    end
  end

  generate
    if (ANGLE_BITS >= 32) begin : g_wide
      assign ph = theta[ANGLE_BITS-1 -: 32];
    end else begin : g_narrow
      assign ph = {theta, {(32-ANGLE_BITS){1'b0}}};
    end
  endgenerate

  // Output register stage
  assign in_ready = !q_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid && !drop;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      q_tag   <= '{degree: degree, order: order, bad: bad};
      q_theta <= ph;
      q_coefs <= coefs;
    end
  end

endmodule
`default_nettype wire

[rtl/thrs_queue.sv]
//------------------------------------------------------------------------------
// thrs_queue: short FIFO between front and back
// Two-entry register FIFO so each side can stall on its own.
//------------------------------------------------------------------------------
`default_nettype none
module thrs_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [WIDTH-1:0]      out_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wp, rp;
  logic [1:0]       cnt;
  logic             push, pop;

  assign in_ready  = cnt != 2'd2;
  assign out_valid = cnt != 2'd0;
  assign out_data  = mem[rp];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_data;
  end

endmodule
`default_nettype wire

[rtl/thrs_back.sv]
//------------------------------------------------------------------------------
// thrs_back: sine/cosine and coefficient combiner
// Pipelined 16-stage CORDIC, then products, rounding and saturation.
//------------------------------------------------------------------------------
`default_nettype none
module thrs_back import thrs_pkg::*; #(
  parameter int COEF_BITS = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire row_tag_t               in_tag,
  input  wire logic [31:0]            in_theta,
  input  wire logic [4*COEF_BITS-1:0] in_coefs,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output row_tag_t                    out_tag,
  output logic [COEF_BITS+1:0]        out_dc,
  output logic [COEF_BITS+1:0]        out_ds
);

  localparam int NS = CORDIC_STEPS + 2;
  localparam int OW = COEF_BITS + 2;
  localparam int PW = COEF_BITS + 18;

  logic                   adv;
  logic                   v   [NS+1];
  row_tag_t               tg  [NS+1];
  logic [4*COEF_BITS-1:0] cf  [NS+1];
  logic [1:0]             qd  [CORDIC_STEPS+1];
  logic signed [33:0]     cx  [CORDIC_STEPS+1];
  logic signed [33:0]     cy  [CORDIC_STEPS+1];
  logic signed [33:0]     cz  [CORDIC_STEPS+1];

  // Whole pipe moves together; output stage drains when taken
  assign adv      = !v[NS] || out_ready;
  assign in_ready = adv;
  assign v[0]  = in_valid;
  assign tg[0] = in_tag;
  assign cf[0] = in_coefs;
  assign qd[0] = in_theta[31:30];
  assign cx[0] = CORDIC_GAIN;
  assign cy[0] = '0;
  assign cz[0] = 34'($unsigned(in_theta[29:0]));

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_ctl
      always_ff @(posedge clk) begin
        if (rst) v[k+1] <= 1'b0;
        else if (adv) v[k+1] <= v[k];
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          tg[k+1] <= tg[k];
          cf[k+1] <= cf[k];
        end
      end
    end
    for (k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
      always_ff @(posedge clk) begin
        if (adv) begin
          qd[k+1] <= qd[k];
          if (!cz[k][33]) begin
            cx[k+1] <= cx[k] - (cy[k] >>> k);
            cy[k+1] <= cy[k] + (cx[k] >>> k);
            cz[k+1] <= cz[k] - atan_turns(4'(k));
          end else begin
            cx[k+1] <= cx[k] + (cy[k] >>> k);
            cy[k+1] <= cy[k] - (cx[k] >>> k);
            cz[k+1] <= cz[k] + atan_turns(4'(k));
          end
        end
      end
    end
  endgenerate

  // Round to Q2.14, clamp, rotate by quadrant
  logic signed [33:0] rx, ry;
  logic signed [15:0] ux, uy, cs, sn;
  assign rx = (cx[CORDIC_STEPS] + 34'sd16384) >>> 15;
  assign ry = (cy[CORDIC_STEPS] + 34'sd16384) >>> 15;
  assign ux = rx > 34'sd16384 ? 16'sd16384 : (rx < -34'sd16384 ? -16'sd16384 : 16'(rx));
  assign uy = ry > 34'sd16384 ? 16'sd16384 : (ry < -34'sd16384 ? -16'sd16384 : 16'(ry));
  always_comb begin
    unique case (qd[CORDIC_STEPS])
      2'd0: begin cs = ux;  sn = uy;  end
      2'd1: begin cs = -uy; sn = ux;  end
      2'd2: begin cs = -ux; sn = -uy; end
      default: begin cs = uy; sn = -ux; end
    endcase
  end

  // Sums and differences of the coefficient pairs
  logic signed [COEF_BITS-1:0] cp, sp, cm, sm;
  logic signed [COEF_BITS:0]   a0, a1, a2, a3;
  assign cp = cf[CORDIC_STEPS][0*COEF_BITS +: COEF_BITS];
  assign sp = cf[CORDIC_STEPS][1*COEF_BITS +: COEF_BITS];
  assign cm = cf[CORDIC_STEPS][2*COEF_BITS +: COEF_BITS];
  assign sm = cf[CORDIC_STEPS][3*COEF_BITS +: COEF_BITS];
  assign a0 = (COEF_BITS+1)'(cp) + (COEF_BITS+1)'(cm);
  assign a1 = (COEF_BITS+1)'(sp) + (COEF_BITS+1)'(sm);
  assign a2 = (COEF_BITS+1)'(sp) - (COEF_BITS+1)'(sm);
  assign a3 = (COEF_BITS+1)'(cp) - (COEF_BITS+1)'(cm);

  // Products, one register stage
  logic signed [PW-1:0] p0, p1, p2, p3;
  always_ff @(posedge clk) begin
    if (adv) begin
      p0 <= PW'(a0) * PW'(cs);
      p1 <= PW'(a1) * PW'(sn);
      p2 <= PW'(a2) * PW'(cs);
      p3 <= PW'(a3) * PW'(sn);
    end
  end

  // Combine, round, saturate
  logic signed [PW:0]   sc, ss, rc, rs;
  logic signed [OW-1:0] dc, ds;
  localparam logic signed [PW:0] HI = (PW+1)'((64'sd1 <<< (OW-1)) - 1);
  localparam logic signed [PW:0] LO = -HI - 1;
  assign sc = ((PW+1)'(p0) + (PW+1)'(p1) + (PW+1)'(8192)) >>> 14;
  assign ss = ((PW+1)'(p2) - (PW+1)'(p3) + (PW+1)'(8192)) >>> 14;
  assign rc = sc > HI ? HI : (sc < LO ? LO : sc);
  assign rs = ss > HI ? HI : (ss < LO ? LO : ss);
  assign dc = OW'(rc);
  assign ds = OW'(rs);

  always_ff @(posedge clk) begin
    if (adv) begin
      out_dc <= tg[NS-1].bad ? '0 : dc;
      out_ds <= (tg[NS-1].bad || tg[NS-1].order == '0) ? '0 : ds;
    end
  end

  assign out_valid = v[NS];
  assign out_tag   = tg[NS];

endmodule
`default_nettype wire

[rtl/tidal_harmonic_row_synthesis_unit.sv]
//------------------------------------------------------------------------------
// tidal_harmonic_row_synthesis_unit: tidal Stokes increments per row
// Front filter and phase former, short queue, CORDIC and combiner back end.
//------------------------------------------------------------------------------
// One coefficient row is accepted per cycle while s_axis_tready is high, and
// each kept row yields one result after the front register, the queue entry,
// 16 CORDIC stages, a product stage and the output register; the back
// pipeline advances as a whole, so throughput is one row per cycle while the
// sink takes results. With valid limits, rows outside them give no result.
// Write configuration only while no rows are in flight.
`default_nettype none
module tidal_harmonic_row_synthesis_unit import thrs_pkg::*; #(
  parameter int TABLE_DEGREE = 100,
  parameter int ANGLE_BITS = 32,
  parameter int COEF_BITS  = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // degree, order, mult_first..mult_sixth, cos_prograde, sin_prograde,
  // cos_retrograde, sin_retrograde (padded to bytes)
  input  wire logic [((38+4*COEF_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // out_degree, out_order, delta_c, delta_s, limits_error (padded to bytes)
  output logic [((15+2*(COEF_BITS+2)+7)/8)*8-1:0]  m_axis_tdata
);

  localparam int OW  = COEF_BITS + 2;
  localparam int ODW = ((15+2*OW+7)/8)*8;
  localparam int QW  = $bits(row_tag_t) + 32 + 4*COEF_BITS;

  logic [ANGLE_BITS-1:0] arg [6];
  logic [DEG_W-1:0]      deg_limit, ord_limit;
  logic [ANGLE_BITS-1:0] beta [6];
  logic [ANGLE_BITS-1:0] sfs;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) arg[i] <= '0;
      deg_limit <= DEG_W'(100);
      ord_limit <= DEG_W'(100);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAMMA, REG_L, REG_LP, REG_F, REG_D, REG_OM:
          arg[cfg_index[2:0]] <= ANGLE_BITS'(cfg_data);
        REG_DEG: deg_limit <= cfg_data[DEG_W-1:0];
        REG_ORD: ord_limit <= cfg_data[DEG_W-1:0];
        default: ;
      endcase
    end
  end

  // Doodson arguments from the fundamental ones
  assign sfs     = arg[3] + arg[5];
  assign beta[0] = arg[0] - sfs;
  assign beta[1] = sfs;
  assign beta[2] = sfs - arg[4];
  assign beta[3] = sfs - arg[1];
  assign beta[4] = '0 - arg[5];
  assign beta[5] = sfs - arg[4] - arg[2];

  logic [MULT_W-1:0] mult [6];
  always_comb begin
    for (int i = 0; i < 6; i++) mult[i] = s_axis_tdata[14+4*i +: 4];
  end

  logic                   f_valid, f_ready;
  row_tag_t               f_tag;
  logic [31:0]            f_theta;
  logic [4*COEF_BITS-1:0] f_coefs;

  thrs_front #(.TABLE_DEGREE(TABLE_DEGREE), .ANGLE_BITS(ANGLE_BITS), .COEF_BITS(COEF_BITS))
  u_front (
    .clk, .rst, .beta, .deg_limit, .ord_limit,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .degree(s_axis_tdata[6:0]), .order(s_axis_tdata[13:7]), .mult,
    .coefs(s_axis_tdata[38 +: 4*COEF_BITS]),
    .q_valid(f_valid), .q_ready(f_ready), .q_tag(f_tag), .q_theta(f_theta),
    .q_coefs(f_coefs)
  );

  logic          b_valid, b_ready;
  logic [QW-1:0] b_data;

  thrs_queue #(.WIDTH(QW)) u_queue (
    .clk, .rst, .in_valid(f_valid), .in_ready(f_ready),
    .in_data({f_tag, f_theta, f_coefs}),
    .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
  );

  row_tag_t          o_tag;
  logic [OW-1:0]     o_dc, o_ds;

  thrs_back #(.COEF_BITS(COEF_BITS)) u_back (
    .clk, .rst, .in_valid(b_valid), .in_ready(b_ready),
    .in_tag(b_data[QW-1 -: $bits(row_tag_t)]),
    .in_theta(b_data[4*COEF_BITS +: 32]),
    .in_coefs(b_data[4*COEF_BITS-1:0]),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_tag(o_tag), .out_dc(o_dc), .out_ds(o_ds)
  );

  assign m_axis_tdata = ODW'({o_tag.bad, o_ds, o_dc, o_tag.order, o_tag.degree});

  // Bad limits always force zero increments
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && o_tag.bad |-> o_dc == '0 && o_ds == '0)
    else $error("nonzero delta with limits error");
  // Order zero rows carry no S increment
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && o_tag.order == '0 |-> o_ds == '0)
    else $error("delta_s nonzero at order zero");
  // A stalled result holds its value
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed under stall");

endmodule
`default_nettype wire
